/* src/updsr_pkg.sv */
// Shared constants and types for the URL path dot-segment resolver.
package updsr_pkg;

	// Sizes of the result buffer and the segment start stack.
	localparam int MAX_PATH_BYTES = 4096;
	localparam int MAX_SEGMENTS   = 256;

	// Derived widths.
	localparam int ADDR_W  = $clog2(MAX_PATH_BYTES);
	localparam int LEN_W   = ADDR_W + 1;
	localparam int SEG_W   = $clog2(MAX_SEGMENTS);
	localparam int DEPTH_W = SEG_W + 1;
	localparam int BYTE_W  = 8;

	// Operation codes of an input transaction.
	localparam logic OP_PATH = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Kind codes of an output transaction.
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	// Characters that the parser looks for.
	localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
	localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
	localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

	// Shape of the segment being collected.
	typedef enum logic [1:0] {
		SHAPE_EMPTY  = 2'd0,
		SHAPE_DOT    = 2'd1,
		SHAPE_DOTDOT = 2'd2,
		SHAPE_OTHER  = 2'd3
	} shape_t;

	// Status reported at the end of a path.
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_SLASH = 3'd1,
		ST_NUL      = 3'd2,
		ST_ESCAPE   = 3'd3,
		ST_TOO_LONG = 3'd4,
		ST_TOO_MANY = 3'd5
	} status_t;

endpackage

/* src/updsr_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module updsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/url_path_dot_segment_resolver_top.sv */
// Top level of the URL path dot-segment resolver.
//
// Input channel (in_valid / in_stall): a transaction is either one path byte
// (operation 0, with end_of_path on the last byte) or a read of one byte of
// the resolved path (operation 1, read_index). Output channel (out_valid /
// out_stall): a status transaction at the end of each path and a data
// transaction for each read. Path bytes that do not end a path give nothing.
// One transaction is accepted in every cycle while the output side keeps up.
// Results pass through the s1 stage (which covers the registered read of the
// result buffer) and then the output register. Resolved bytes live in a
// 4096-byte buffer RAM and segment start offsets in a 256-entry stack RAM;
// the top of the stack is held in a register and refilled from the RAM in
// the cycle after a pop. A read sees every byte written by earlier transactions.
// Reset clears the path state, the stack depth and both pipeline stages; the
// buffers are not cleared and need no time after reset. When out_stall holds
// a full output register, a result in the s1 stage holds too and in_stall
// rises until the output register drains.
module url_path_dot_segment_resolver_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic [updsr_pkg::BYTE_W-1:0]        path_byte,
	input  logic                                end_of_path,
	input  logic [updsr_pkg::ADDR_W-1:0]        read_index,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                kind,
	output logic [updsr_pkg::BYTE_W-1:0]        data_byte,
	output logic [updsr_pkg::LEN_W-1:0]         result_length,
	output logic [2:0]                          status
);

	import updsr_pkg::*;

	// Path state.
	logic [LEN_W-1:0]   wp_q, wp_d;
	logic [DEPTH_W-1:0] depth_q, depth_d;
	shape_t             shape_q, shape_d;
	logic               first_q, first_d;
	logic               slash_q, slash_d;
	status_t            err_q, err_d;
	logic [LEN_W-1:0]   start_q, start_d;
	logic [LEN_W-1:0]   final_len_q;
	logic [ADDR_W-1:0]  top_q, top_d;
	logic               refill_q, refill_d;

	// Per-transaction results.
	logic [LEN_W-1:0]   len_d;
	status_t            stat_d;
	logic               ends_open;
	logic               close_req;
	logic               close_slash;
	logic               pop;

	// Memory ports.
	logic                st_we;
	logic [ADDR_W-1:0]   st_waddr;
	logic [BYTE_W-1:0]   st_wdata;
	logic                st_re;
	logic [BYTE_W-1:0]   st_rdata;
	logic                sk_we;
	logic                sk_re;
	logic [SEG_W-1:0]    sk_waddr;
	logic [SEG_W-1:0]    sk_raddr;
	logic [ADDR_W-1:0]   sk_wdata;
	logic [ADDR_W-1:0]   sk_rdata;
	logic [DEPTH_W-1:0]  depth_m2;

	// Pipeline.
	logic               acc;
	logic               path_acc;
	logic               produces;
	logic               valid_s1;
	logic               kind_s1;
	logic [LEN_W-1:0]   length_s1;
	status_t            status_s1;
	logic               adv_s1;
	logic               out_valid_q;
	logic               kind_q;
	logic [BYTE_W-1:0]  data_q;
	logic [LEN_W-1:0]   length_q;
	status_t            status_q;

	// Handshake.
	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign acc      = in_valid && !in_stall;
	assign path_acc = acc && (operation == OP_PATH);
	assign produces = (operation == OP_READ) || end_of_path;
	assign st_re    = acc && (operation == OP_READ);
	assign depth_m2 = depth_q - DEPTH_W'(2);

	// Result buffer; the read index always falls inside it.
	updsr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_PATH_BYTES)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (read_index),
		.rdata (st_rdata)
	);

	// Segment start stack.
	updsr_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (MAX_SEGMENTS)
	) u_stack (
		.clk   (clk),
		.we    (sk_we),
		.waddr (sk_waddr),
		.wdata (sk_wdata),
		.re    (sk_re),
		.raddr (sk_raddr),
		.rdata (sk_rdata)
	);

	// Byte parser: one path byte, then an optional segment close, then the
	// end-of-path status and restart.
	always_comb begin
		wp_d        = wp_q;
		depth_d     = depth_q;
		shape_d     = shape_q;
		first_d     = first_q;
		slash_d     = slash_q;
		err_d       = err_q;
		start_d     = start_q;
		top_d       = refill_q ? sk_rdata : top_q;
		refill_d    = 1'b0;
		st_we       = 1'b0;
		st_waddr    = wp_q[ADDR_W-1:0];
		st_wdata    = path_byte;
		sk_we       = 1'b0;
		sk_re       = 1'b0;
		sk_waddr    = depth_q[SEG_W-1:0];
		sk_raddr    = depth_m2[SEG_W-1:0];
		sk_wdata    = start_q[ADDR_W-1:0];
		close_req   = 1'b0;
		close_slash = 1'b0;
		ends_open   = 1'b0;
		pop         = 1'b0;
		len_d       = '0;
		stat_d      = err_q;
		if (path_acc) begin
			// Take the byte.
			if (first_q) begin
				first_d = 1'b0;
				if (path_byte != CHAR_SLASH) begin
					err_d = ST_NO_SLASH;
				end else begin
					st_we    = 1'b1;
					st_waddr = '0;
					st_wdata = CHAR_SLASH;
					wp_d     = LEN_W'(1);
					slash_d  = 1'b1;
				end
			end else if (path_byte == CHAR_NUL) begin
				if (err_q != ST_NO_SLASH) begin
					err_d = ST_NUL;
				end
			end else if (err_q != ST_OK) begin
				// After an error only NUL bytes are watched.
			end else if (path_byte == CHAR_SLASH) begin
				if (!slash_q) begin
					close_req   = 1'b1;
					close_slash = 1'b1;
				end
				slash_d = 1'b1;
			end else begin
				slash_d = 1'b0;
				case (shape_q)
					SHAPE_EMPTY: begin
						start_d = wp_q;
						shape_d = (path_byte == CHAR_DOT) ? SHAPE_DOT : SHAPE_OTHER;
					end
					SHAPE_DOT: begin
						shape_d = (path_byte == CHAR_DOT) ? SHAPE_DOTDOT : SHAPE_OTHER;
					end
					default: begin
						shape_d = SHAPE_OTHER;
					end
				endcase
				if (wp_q >= LEN_W'(MAX_PATH_BYTES)) begin
					err_d = ST_TOO_LONG;
				end else begin
					st_we = 1'b1;
					wp_d  = wp_q + LEN_W'(1);
				end
			end

			// An open segment closes at the end of the path.
			if (end_of_path && (err_d == ST_OK) && !slash_d) begin
				ends_open = (shape_d == SHAPE_OTHER);
				close_req = 1'b1;
			end

			// Close the segment: drop it, pop the previous one, or keep it.
			if (close_req) begin
				case (shape_d)
					SHAPE_DOT: begin
						wp_d = start_d;
					end
					SHAPE_DOTDOT: begin
						wp_d = start_d;
						if (depth_d == '0) begin
							err_d = ST_ESCAPE;
						end else begin
							pop      = 1'b1;
							depth_d  = depth_d - DEPTH_W'(1);
							wp_d     = {1'b0, top_q};
							refill_d = (depth_d != '0);
							sk_re    = refill_d;
						end
					end
					SHAPE_OTHER: begin
						if (depth_d >= DEPTH_W'(MAX_SEGMENTS)) begin
							err_d = ST_TOO_MANY;
						end else begin
							sk_we    = 1'b1;
							sk_wdata = start_d[ADDR_W-1:0];
							top_d    = start_d[ADDR_W-1:0];
							depth_d  = depth_d + DEPTH_W'(1);
							if (close_slash) begin
								if (wp_d >= LEN_W'(MAX_PATH_BYTES)) begin
									err_d = ST_TOO_LONG;
								end else begin
									st_we    = 1'b1;
									st_waddr = wp_d[ADDR_W-1:0];
									st_wdata = CHAR_SLASH;
									wp_d     = wp_d + LEN_W'(1);
								end
							end
						end
					end
					default: begin
					end
				endcase
				shape_d = SHAPE_EMPTY;
			end

			// Status and restart at the end of the path.
			if (end_of_path) begin
				stat_d = err_d;
				if (err_d != ST_OK) begin
					len_d = '0;
				end else if (depth_d == '0) begin
					len_d = LEN_W'(1);
				end else if (slash_d || ends_open) begin
					len_d = wp_d;
				end else begin
					len_d = wp_d - LEN_W'(1);
				end
				wp_d    = LEN_W'(1);
				depth_d = '0;
				shape_d = SHAPE_EMPTY;
				first_d = 1'b1;
				slash_d = 1'b0;
				err_d   = ST_OK;
				start_d = '0;
			end
		end
	end

	// Path state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= LEN_W'(1);
			depth_q     <= '0;
			shape_q     <= SHAPE_EMPTY;
			first_q     <= 1'b1;
			slash_q     <= 1'b0;
			err_q       <= ST_OK;
			start_q     <= '0;
			final_len_q <= '0;
			refill_q    <= 1'b0;
		end else begin
			wp_q     <= wp_d;
			depth_q  <= depth_d;
			shape_q  <= shape_d;
			first_q  <= first_d;
			slash_q  <= slash_d;
			err_q    <= err_d;
			start_q  <= start_d;
			refill_q <= refill_d;
			if (path_acc && end_of_path) begin
				final_len_q <= len_d;
			end
		end
	end

	// Cached top of the segment stack.
	always_ff @(posedge clk) begin
		top_q <= top_d;
	end

	// Stage s1 valid: waits for the buffer read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc && produces) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage s1 payload.
	always_ff @(posedge clk) begin
		if (acc && produces) begin
			if (operation == OP_READ) begin
				kind_s1   <= KIND_READ;
				length_s1 <= final_len_q;
				status_s1 <= ST_OK;
			end else begin
				kind_s1   <= KIND_STATUS;
				length_s1 <= len_d;
				status_s1 <= stat_d;
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			kind_q   <= kind_s1;
			data_q   <= (kind_s1 == KIND_READ) ? st_rdata : '0;
			length_q <= length_s1;
			status_q <= status_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign data_byte     = data_q;
	assign result_length = length_q;
	assign status        = status_q;

	// The stack never holds more than its capacity.
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(MAX_SEGMENTS))
		else $error("segment stack depth beyond capacity");

	// The write pointer never runs past the buffer end.
	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= LEN_W'(MAX_PATH_BYTES))
		else $error("write pointer beyond buffer end");

	// A pop never uses the cached top while its refill is still in flight.
	a_refill_pop: assert property (@(posedge clk) disable iff (!arst_n)
		refill_q |-> !pop)
		else $error("pop during stack top refill");

	// The end of a path restarts the parser with an empty stack.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(path_acc && end_of_path) |=> (first_q && (depth_q == '0)))
		else $error("path state not restarted after end of path");

endmodule
